// ----- src/mecanum_wheel_speed_mixer_macros.svh -----
// Assertion macros for the mecanum wheel speed mixer.
// Needs i_clk and i_rst_n in the including module's scope.
`ifndef MECANUM_WHEEL_SPEED_MIXER_MACROS_SVH
`define MECANUM_WHEEL_SPEED_MIXER_MACROS_SVH

// Implication checked while out of reset.
`define MWSM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mwsm assertion failed");

// Plain check at every edge, reset included.
`define MWSM_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) (expr)) \
        else $error("mwsm assertion failed");

`endif

// ----- src/mwsm_pkg.sv -----
// Shared types, constants and the sine table for the wheel speed mixer.
// No dependencies.
package mwsm_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SCALE_W          = 14 + IDX_W;
    localparam int SPEED_W          = 15;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 15'd30000;
    localparam longint HALF_PI_Q30  = 64'sd1686629713;
    localparam longint Q30_ONE      = 64'sd1 <<< 30;

    localparam int WHEEL_W  = 19;               // exact mixed wheel speed
    localparam int MAG_W    = 18;               // |wheel|
    localparam int PROD_W   = MAG_W + SPEED_W;  // |wheel| * max
    localparam int DIV_STAGES     = 5;
    localparam int BITS_PER_STAGE = SPEED_W / DIV_STAGES;
    localparam int N_STAGES = 2 + 3 + DIV_STAGES + 1;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
        logic        [15:0] heading;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] wheel_front_right;
        logic signed [15:0] wheel_front_left;
        logic signed [15:0] wheel_rear_left;
        logic signed [15:0] wheel_rear_right;
    } t_wheels;

    // Floored Q15 products of the rotation, plus the yaw term.
    typedef struct packed {
        logic signed [15:0] p_yc;
        logic signed [15:0] p_xs;
        logic signed [15:0] p_xc;
        logic signed [15:0] p_ys;
        logic signed [15:0] yaw;
    } t_rot;

    typedef struct packed {
        logic              neg;
        logic [15:0]       wlo;
        logic [PROD_W-1:0] dvd;
    } t_lane;

    typedef struct packed {
        t_lane [3:0]      lane;
        logic             scale;
        logic [MAG_W-1:0] mag;
    } t_mix;

    typedef struct packed {
        logic               neg;
        logic [15:0]        wlo;
        logic [SPEED_W-1:0] q;
    } t_quo;

    typedef struct packed {
        t_quo [3:0] lane;
        logic       scale;
    } t_div;

    typedef logic [15:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    // term * x * x in Q30, each product truncated toward zero
    function automatic longint q30_sq_mul(input longint t, input longint x);
        longint p;
        p = (t * x) / Q30_ONE;
        return (p * x) / Q30_ONE;
    endfunction

    // Quarter-wave sine in Q1.15, Taylor series in Q30, rounded half up.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint x;
        longint term;
        longint sum;
        longint v;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (longint'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            term = x;
            sum  = x;
            // divisors are (2k)(2k+1) for k = 1..7
            term = -q30_sq_mul(term, x) / 64'sd6;   sum = sum + term;
            term = -q30_sq_mul(term, x) / 64'sd20;  sum = sum + term;
            term = -q30_sq_mul(term, x) / 64'sd42;  sum = sum + term;
            term = -q30_sq_mul(term, x) / 64'sd72;  sum = sum + term;
            term = -q30_sq_mul(term, x) / 64'sd110; sum = sum + term;
            term = -q30_sq_mul(term, x) / 64'sd156; sum = sum + term;
            term = -q30_sq_mul(term, x) / 64'sd210; sum = sum + term;
            if (sum < 0) sum = 0;
            v = (sum + 64'sd16384) / 64'sd32768;
            if (v > 32767) v = 32767;
            rom[i] = v[15:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    function automatic logic signed [16:0] sine_lookup(input logic [15:0] angle);
        logic [SCALE_W-1:0] scaled;
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   addr;
        logic signed [16:0] v;
        scaled = SCALE_W'(angle[13:0]) * SCALE_W'(SINE_TABLE_DEPTH);
        idx    = scaled[SCALE_W-1:14];
        addr   = angle[14] ? IDX_W'(SINE_TABLE_DEPTH) - idx : idx;
        v      = $signed({1'b0, SINE_ROM[addr]});
        return angle[15] ? -v : v;
    endfunction

endpackage

// ----- src/mecanum_wheel_speed_mixer.sv -----
// Mecanum wheel speed mixer: top level with handshake, config and output stage.
// Depends on mwsm_pkg, mwsm_rot, mwsm_mix, mwsm_div and the macros header.
//
// Takes one command beat (vel_x, vel_y, yaw_rate, heading) per clock while
// o_stall is low and returns one beat of four wheel speeds. The translation is
// rotated by the heading using a Q1.15 quarter-wave sine table, the four
// wheels are mixed, and if the largest |wheel| exceeds max_wheel_speed every
// wheel becomes wheel * max / largest, truncated toward zero. Throughput is
// one beat per cycle unless i_stall holds it: the pipeline runs 2 stages of
// lookup and multiply, 3 of mixing, max search and dividend product, 5 of a
// restoring divider (3 quotient bits per stage, four lanes), and one output
// register. Each stage has its own valid bit and only holds when it is full
// and the stage after it holds, so empty slots fill in under a downstream
// stall. Write max_wheel_speed (reset 30000) only while no beat is in flight.
`include "mecanum_wheel_speed_mixer_macros.svh"
module mecanum_wheel_speed_mixer import mwsm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_cmd               i_cmd,
    output logic               o_valid,
    input  logic               i_stall,
    output t_wheels            o_wheels,
    input  logic               i_cfg_we,
    input  logic [SPEED_W-1:0] i_cfg_wdata
);

    logic [N_STAGES-1:0] r_v;
    logic [N_STAGES-1:0] en;
    logic [SPEED_W-1:0]  r_max_speed;
    t_rot                rot;
    t_mix                mix;
    t_div                div;
    logic [15:0]         w_res [4];
    t_wheels             r_out;

    // a stage advances when it is empty or the next one advances
    always_comb begin
        en[N_STAGES-1] = !r_v[N_STAGES-1] || !i_stall;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_max_speed <= MAX_SPEED_RESET;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < N_STAGES; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
            if (i_cfg_we) r_max_speed <= i_cfg_wdata;
        end
    end

    mwsm_rot u_rot (
        .i_clk (i_clk),
        .i_en  (en[1:0]),
        .i_cmd (i_cmd),
        .o_rot (rot)
    );

    mwsm_mix u_mix (
        .i_clk (i_clk),
        .i_en  (en[4:2]),
        .i_rot (rot),
        .i_max (r_max_speed),
        .o_mix (mix)
    );

    mwsm_div u_div (
        .i_clk (i_clk),
        .i_en  (en[N_STAGES-2:5]),
        .i_mix (mix),
        .o_div (div)
    );

    // apply the sign to the quotient, or pass the unscaled wheel
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (div.scale) begin
                w_res[j] = div.lane[j].neg ? -{1'b0, div.lane[j].q}
                                           :  {1'b0, div.lane[j].q};
            end else begin
                w_res[j] = div.lane[j].wlo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[N_STAGES-1]) begin
            r_out.wheel_front_right <= w_res[0];
            r_out.wheel_front_left  <= w_res[1];
            r_out.wheel_rear_left   <= w_res[2];
            r_out.wheel_rear_right  <= w_res[3];
        end
    end

    assign o_valid  = r_v[N_STAGES-1];
    assign o_wheels = r_out;

    // no downstream stall means the pipeline never pushes back
    `MWSM_ASSERT_IMP(a_no_backpressure, !i_stall, !o_stall)
    // delivered front right and rear left wheels lie within the configured limit
    `MWSM_ASSERT_IMP(a_fr_limit, o_valid,
        ($signed(o_wheels.wheel_front_right) <= $signed({1'b0, r_max_speed})) &&
        ($signed(o_wheels.wheel_front_right) >= -$signed({1'b0, r_max_speed})))
    `MWSM_ASSERT_IMP(a_rl_limit, o_valid,
        ($signed(o_wheels.wheel_rear_left) <= $signed({1'b0, r_max_speed})) &&
        ($signed(o_wheels.wheel_rear_left) >= -$signed({1'b0, r_max_speed})))
    // reset empties the pipeline
    `MWSM_ASSERT_IMP(a_reset_empty, $past(!i_rst_n), r_v == '0)

endmodule

// ----- src/mwsm_rot.sv -----
// Heading rotation: sine/cosine lookup, then four floored Q15 products.
// Depends on mwsm_pkg.
module mwsm_rot import mwsm_pkg::*; (
    input  logic       i_clk,
    input  logic [1:0] i_en,
    input  t_cmd       i_cmd,
    output t_rot       o_rot
);

    logic signed [16:0] r_sin, r_cos;
    logic signed [15:0] r_vx, r_vy, r_om;
    t_rot               r_rot;
    logic signed [32:0] yc, xs, xc, ys;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sin <= sine_lookup(i_cmd.heading);
            r_cos <= sine_lookup(16'(i_cmd.heading + 16'd16384));
            r_vx  <= i_cmd.vel_x;
            r_vy  <= i_cmd.vel_y;
            r_om  <= i_cmd.yaw_rate;
        end
    end

    assign yc = r_vy * r_cos;
    assign xs = r_vx * r_sin;
    assign xc = r_vx * r_cos;
    assign ys = r_vy * r_sin;

    // >>> 15 always fits in 16 bits here
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rot.p_yc <= yc[30:15];
            r_rot.p_xs <= xs[30:15];
            r_rot.p_xc <= xc[30:15];
            r_rot.p_ys <= ys[30:15];
            r_rot.yaw  <= r_om;
        end
    end

    assign o_rot = r_rot;

endmodule

// ----- src/mwsm_mix.sv -----
// Wheel mixing, magnitude/max search and dividend product.
// Depends on mwsm_pkg.
module mwsm_mix import mwsm_pkg::*; (
    input  logic               i_clk,
    input  logic [2:0]         i_en,
    input  t_rot               i_rot,
    input  logic [SPEED_W-1:0] i_max,
    output t_mix               o_mix
);

    logic signed [WHEEL_W-1:0] fb, lr, om;
    logic signed [WHEEL_W-1:0] r_w [4];
    logic signed [WHEEL_W-1:0] w_abs [4];
    logic [MAG_W-1:0]          r_a [4];
    logic [3:0]                r_neg;
    logic [15:0]               r_wlo [4];
    logic [MAG_W-1:0]          r_m;
    logic [MAG_W-1:0]          m01, m23;
    t_mix                      r_mix;

    assign fb = WHEEL_W'(i_rot.p_yc) + WHEEL_W'(i_rot.p_xs);
    assign lr = WHEEL_W'(i_rot.p_xc) - WHEEL_W'(i_rot.p_ys);
    assign om = WHEEL_W'(i_rot.yaw);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_w[0] <= lr - fb + om;
            r_w[1] <= fb + lr + om;
            r_w[2] <= fb - lr + om;
            r_w[3] <= om - fb - lr;
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_abs[j] = r_w[j][WHEEL_W-1] ? -r_w[j] : r_w[j];
        end
        m01 = (w_abs[0][MAG_W-1:0] > w_abs[1][MAG_W-1:0]) ?
              w_abs[0][MAG_W-1:0] : w_abs[1][MAG_W-1:0];
        m23 = (w_abs[2][MAG_W-1:0] > w_abs[3][MAG_W-1:0]) ?
              w_abs[2][MAG_W-1:0] : w_abs[3][MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int j = 0; j < 4; j++) begin
                r_a[j]   <= w_abs[j][MAG_W-1:0];
                r_neg[j] <= r_w[j][WHEEL_W-1];
                r_wlo[j] <= r_w[j][15:0];
            end
            r_m <= (m01 > m23) ? m01 : m23;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int j = 0; j < 4; j++) begin
                r_mix.lane[j].dvd <= PROD_W'(r_a[j]) * PROD_W'(i_max);
                r_mix.lane[j].neg <= r_neg[j];
                r_mix.lane[j].wlo <= r_wlo[j];
            end
            r_mix.scale <= r_m > MAG_W'(i_max);
            r_mix.mag   <= r_m;
        end
    end

    assign o_mix = r_mix;

endmodule

// ----- src/mwsm_div.sv -----
// Pipelined restoring divider, four lanes, three quotient bits per stage.
// Depends on mwsm_pkg.
module mwsm_div import mwsm_pkg::*; (
    input  logic                  i_clk,
    input  logic [DIV_STAGES-1:0] i_en,
    input  t_mix                  i_mix,
    output t_div                  o_div
);

    typedef struct packed {
        logic               neg;
        logic [15:0]        wlo;
        logic [MAG_W-1:0]   rem;
        logic [SPEED_W-1:0] low;
        logic [SPEED_W-1:0] q;
    } t_dlane;

    typedef struct packed {
        t_dlane [3:0]     lane;
        logic             scale;
        logic [MAG_W-1:0] mag;
    } t_dst;

    t_dst r_st [DIV_STAGES];
    t_dst src  [DIV_STAGES];
    t_dst nxt  [DIV_STAGES];

    // dividend < mag * 2^15 when scaling, so the upper part starts below mag
    always_comb begin
        src[0].scale = i_mix.scale;
        src[0].mag   = i_mix.mag;
        for (int j = 0; j < 4; j++) begin
            src[0].lane[j].neg = i_mix.lane[j].neg;
            src[0].lane[j].wlo = i_mix.lane[j].wlo;
            src[0].lane[j].rem = i_mix.lane[j].dvd[PROD_W-1:SPEED_W];
            src[0].lane[j].low = i_mix.lane[j].dvd[SPEED_W-1:0];
            src[0].lane[j].q   = '0;
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        if (s > 0) begin : g_src
            assign src[s] = r_st[s-1];
        end

        always_comb begin
            logic [MAG_W:0] t;
            logic           ge;
            nxt[s] = src[s];
            for (int j = 0; j < 4; j++) begin
                for (int b = 0; b < BITS_PER_STAGE; b++) begin
                    t  = {nxt[s].lane[j].rem, nxt[s].lane[j].low[SPEED_W-1]};
                    ge = t >= {1'b0, nxt[s].mag};
                    if (ge) t = t - {1'b0, nxt[s].mag};
                    nxt[s].lane[j].rem = t[MAG_W-1:0];
                    nxt[s].lane[j].low = {nxt[s].lane[j].low[SPEED_W-2:0], 1'b0};
                    nxt[s].lane[j].q   = {nxt[s].lane[j].q[SPEED_W-2:0], ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_st[s] <= nxt[s];
            end
        end
    end

    always_comb begin
        o_div.scale = r_st[DIV_STAGES-1].scale;
        for (int j = 0; j < 4; j++) begin
            o_div.lane[j].neg = r_st[DIV_STAGES-1].lane[j].neg;
            o_div.lane[j].wlo = r_st[DIV_STAGES-1].lane[j].wlo;
            o_div.lane[j].q   = r_st[DIV_STAGES-1].lane[j].q;
        end
    end

endmodule

// ----- bench/mecanum_wheel_speed_mixer_test.sv -----
// Testbench for the mecanum wheel speed mixer: random and directed command beats,
// scoreboard with its own wheel speed predictor. Depends on mwsm_pkg and the RTL.
`timescale 1ns / 100ps

class wheel_scoreboard;
    mwsm_pkg::t_wheels pending_wheels[$];
    int                errors;
    logic [15:0]       quarter_sine[0:256];
    int unsigned       speed_limit;

    function new();
        longint x, term, sum, v;
        errors = 0;
        speed_limit = 30000;
        for (int i = 0; i <= 256; i++) begin
            x    = (longint'(i) * 64'sd1686629713) / 256;
            term = x;
            sum  = x;
            for (int k = 1; k <= 7; k++) begin
                term = (term * x) / (64'sd1 <<< 30);
                term = (term * x) / (64'sd1 <<< 30);
                term = -term / longint'((2 * k) * (2 * k + 1));
                sum  = sum + term;
            end
            if (sum < 0) sum = 0;
            v = (sum + 16384) / 32768;
            if (v > 32767) v = 32767;
            quarter_sine[i] = v[15:0];
        end
    endfunction

    function longint heading_sine(logic [15:0] angle);
        int unsigned idx;
        longint      v;
        idx = (int'(angle[13:0]) * 256) >> 14;
        v   = angle[14] ? quarter_sine[256 - idx] : quarter_sine[idx];
        return angle[15] ? -v : v;
    endfunction

    function longint floor_q15(longint v);
        return v >>> 15;
    endfunction

    function void note_command(mwsm_pkg::t_cmd cmd);
        longint vx, vy, om, s, c, fb, lr, peak, mag;
        longint w[4];
        mwsm_pkg::t_wheels exp_w;
        vx = cmd.vel_x;
        vy = cmd.vel_y;
        om = cmd.yaw_rate;
        s  = heading_sine(cmd.heading);
        c  = heading_sine(cmd.heading + 16'd16384);
        fb = floor_q15(vy * c) + floor_q15(vx * s);
        lr = floor_q15(vx * c) - floor_q15(vy * s);
        w[0] = -fb + lr + om;
        w[1] = fb + lr + om;
        w[2] = fb - lr + om;
        w[3] = -fb - lr + om;
        peak = 0;
        for (int j = 0; j < 4; j++) begin
            mag = w[j] < 0 ? -w[j] : w[j];
            if (mag > peak) peak = mag;
        end
        if (peak > speed_limit)
            for (int j = 0; j < 4; j++) w[j] = (w[j] * longint'(speed_limit)) / peak;
        exp_w.wheel_front_right = w[0][15:0];
        exp_w.wheel_front_left  = w[1][15:0];
        exp_w.wheel_rear_left   = w[2][15:0];
        exp_w.wheel_rear_right  = w[3][15:0];
        pending_wheels.push_back(exp_w);
    endfunction

    function void check_wheels(mwsm_pkg::t_wheels got);
        mwsm_pkg::t_wheels exp_w;
        if (pending_wheels.size() == 0) begin
            $display("%0t: unexpected wheel beat %h", $time, got);
            errors++;
            return;
        end
        exp_w = pending_wheels.pop_front();
        if (got.wheel_front_right !== exp_w.wheel_front_right) begin
            $display("%0t: front right exp %0d got %0d", $time,
                     exp_w.wheel_front_right, got.wheel_front_right);
            errors++;
        end
        if (got.wheel_front_left !== exp_w.wheel_front_left) begin
            $display("%0t: front left exp %0d got %0d", $time,
                     exp_w.wheel_front_left, got.wheel_front_left);
            errors++;
        end
        if (got.wheel_rear_left !== exp_w.wheel_rear_left) begin
            $display("%0t: rear left exp %0d got %0d", $time,
                     exp_w.wheel_rear_left, got.wheel_rear_left);
            errors++;
        end
        if (got.wheel_rear_right !== exp_w.wheel_rear_right) begin
            $display("%0t: rear right exp %0d got %0d", $time,
                     exp_w.wheel_rear_right, got.wheel_rear_right);
            errors++;
        end
    endfunction
endclass

module mecanum_wheel_speed_mixer_test;
    import mwsm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_stall;
    t_cmd    i_cmd;
    logic    o_valid;
    logic    i_stall;
    t_wheels o_wheels;
    logic    i_cfg_we;
    logic [SPEED_W-1:0] i_cfg_wdata;

    wheel_scoreboard board;
    bit  quiet_tail;   // no idling near the end of the run
    bit  long_hold;    // receiver holds off to back the pipeline up
    int  idle_cycles;

    mecanum_wheel_speed_mixer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_cmd(i_cmd),
        .o_valid(o_valid), .i_stall(i_stall), .o_wheels(o_wheels),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Scoreboard hooks: sample at the edge, before the nonblocking updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) board.note_command(i_cmd);
        if (i_rst_n && o_valid && !i_stall) board.check_wheels(o_wheels);
    end

    // Watchdog: counts edges where no beat moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, one long hold on request.
    initial begin
        int burst;
        i_stall = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_stall <= 1;
                repeat (300) @(posedge i_clk);
                i_stall <= 0;
                long_hold = 0;
                @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 19);
                i_stall <= 1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                i_stall <= 0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // Offer one command and hold it until the block takes it.
    task automatic send_command(input t_cmd cmd);
        if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_cmd   <= cmd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_fields(input logic [15:0] vx, input logic [15:0] vy,
                               input logic [15:0] om, input logic [15:0] hd);
        t_cmd cmd;
        cmd.vel_x    = vx;
        cmd.vel_y    = vy;
        cmd.yaw_rate = om;
        cmd.heading  = hd;
        send_command(cmd);
    endtask

    // Drain the pipeline, then write the speed limit while idle.
    task automatic set_speed_limit(input logic [SPEED_W-1:0] limit);
        i_valid <= 0;
        @(posedge i_clk);
        while (board.pending_wheels.size() != 0) @(posedge i_clk);
        repeat (N_STAGES + 4) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we <= 0;
        board.speed_limit = limit;
        @(posedge i_clk);
    endtask

    // Small and mid-range commands so the limit often is not hit, half full scale.
    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 2000)) - 16'd1000;
            1: return 16'($urandom_range(0, 20000)) - 16'd10000;
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_block(input int count);
        for (int n = 0; n < count; n++)
            send_fields(pick_speed(), pick_speed(), pick_speed(), 16'($urandom));
    endtask

    initial begin
        board       = new();
        quiet_tail  = 0;
        long_hold   = 0;
        i_rst_n     = 0;
        i_valid     = 0;
        i_cmd       = '0;
        i_cfg_we    = 0;
        i_cfg_wdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed beats at the reset limit: field extremes, quadrant edges.
        send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_fields(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
        send_fields(16'h8000, 16'h0000, 16'h0000, 16'h4000);
        send_fields(16'h0000, 16'h7fff, 16'h0000, 16'h8000);
        send_fields(16'h0000, 16'h8000, 16'h0000, 16'hc000);
        send_fields(16'h0000, 16'h0000, 16'h7fff, 16'hffff);
        send_fields(16'h0000, 16'h0000, 16'h8000, 16'h3fff);
        send_fields(16'h8000, 16'h8000, 16'h8000, 16'h2000);
        send_fields(16'h7fff, 16'h7fff, 16'h7fff, 16'h6000);
        send_fields(16'h7fff, 16'h8000, 16'h7fff, 16'ha000);
        send_fields(16'd100, 16'hff9c, 16'd50, 16'h7fff);
        send_fields(16'hffff, 16'hffff, 16'hffff, 16'h8001);
        send_fields(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);

        // Zero limit: any nonzero wheel set scales to zeros.
        set_speed_limit(15'd0);
        send_fields(16'd1, 16'd0, 16'd0, 16'd0);
        send_fields(16'h8000, 16'h7fff, 16'h8000, 16'h1234);
        send_fields(16'h0000, 16'h0000, 16'h0000, 16'h5678);
        set_speed_limit(15'd1);
        send_fields(16'd1, 16'd1, 16'd1, 16'd0);
        send_fields(16'h8000, 16'h8000, 16'h8000, 16'hc000);
        set_speed_limit(15'd32767);
        send_fields(16'h8000, 16'h8000, 16'h8000, 16'h2000);
        send_fields(16'h7fff, 16'h7fff, 16'h7fff, 16'he000);

        random_block(200);
        set_speed_limit(15'd1);
        random_block(100);
        set_speed_limit(15'($urandom_range(1, 32767)));
        random_block(150);

        // Receiver holds off while commands keep coming.
        long_hold = 1;
        random_block(150);
        set_speed_limit(15'd30000);
        random_block(150);
        set_speed_limit(15'd500);
        random_block(150);
        set_speed_limit(15'd32767);
        random_block(100);
        quiet_tail = 1;
        random_block(130);
        i_valid <= 0;

        fork
            while (board.pending_wheels.size() != 0) @(posedge i_clk);
            begin
                repeat (WATCHDOG_LIMIT) @(posedge i_clk);
            end
        join_any
        disable fork;
        repeat (N_STAGES + 4) @(posedge i_clk);
        if (board.pending_wheels.size() == 0 && board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+src
src/mwsm_pkg.sv
src/mwsm_rot.sv
src/mwsm_mix.sv
src/mwsm_div.sv
src/mecanum_wheel_speed_mixer.sv
bench/mecanum_wheel_speed_mixer_test.sv
